FILE: rtl/core/caf_pkg.sv
// ---------------------------------------------------------------------------
// CAN receive acceptance filter package
// Shared types and constants for the acceptance filter table and its
// compare unit.
// ---------------------------------------------------------------------------
package caf_pkg;

    // Field widths of the standard frame format.
    localparam int unsigned IDENT_W = 11;
    localparam int unsigned KEY_W   = IDENT_W + 1;
    localparam int unsigned DLC_W   = 4;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned COUNT_W = 5;

    // Item actions.
    localparam logic ACT_CONFIG = 1'b0;
    localparam logic ACT_FRAME  = 1'b1;

    // Configure status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ILLEGAL = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    // One stored table entry. The RTR bit of the mask is always set,
    // so only the identifier part of the mask is kept.
    typedef struct packed {
        logic [KEY_W-1:0]   ident;
        logic [IDENT_W-1:0] mask;
    } entry_t;

    // Verdict of the compare unit for one entry.
    typedef struct packed {
        logic hit;
        logic deliver;
    } verdict_t;

endpackage

FILE: rtl/core/caf_compare.sv
// ---------------------------------------------------------------------------
// CAN acceptance filter compare unit
// Checks one table entry against the received frame key. An entry that was
// never written acts as identifier zero with a full mask and no handler.
// ---------------------------------------------------------------------------
module caf_compare (
    input  logic [caf_pkg::KEY_W-1:0] frame_key,
    input  caf_pkg::entry_t           entry,
    input  logic                      entry_valid,
    output caf_pkg::verdict_t         verdict
);

    logic [caf_pkg::KEY_W-1:0] eff_ident;
    logic [caf_pkg::KEY_W-1:0] eff_mask;

    // Substitute the reset entry for one that was never written.
    always_comb
    begin
        if (entry_valid)
        begin
            eff_ident = entry.ident;
            eff_mask  = {1'b1, entry.mask};
        end
        else
        begin
            eff_ident = '0;
            eff_mask  = '1;
        end
    end

    // Masked identifier compare; only written entries have a handler.
    always_comb
    begin
        verdict.hit     = (((frame_key ^ eff_ident) & eff_mask) == '0);
        verdict.deliver = entry_valid;
    end

endmodule

FILE: rtl/core/can_rx_acceptance_filter.sv
// ---------------------------------------------------------------------------
// CAN receive acceptance filter
// Table of identifier/mask entries for standard frames, searched one entry
// per cycle by a single compare unit under a small sequencer.
// ---------------------------------------------------------------------------
// Usage: present a word on the input ports with start high while busy is
// low. action selects between writing a table entry and matching a received
// frame. Each word yields exactly one result word, shown for one cycle with
// done high; the receiver cannot stall, so it must take the word then.
// A configure word returns its result on the next cycle and leaves busy low.
// A frame word reads the table through one registered read port, one entry
// per cycle, stopping at the first hit or after the last active entry;
// with no entry active it returns its result on the next cycle. At most
// min(active_entries, NUM_ENTRIES) entries are examined.
// busy stays high until the cycle in which done is shown. cfg_we writes
// active_entries; the user must use it only while the block is idle, which
// the block does not enforce. Reset clears the sequencer, the handler bits
// and active_entries; an entry without its handler bit reads as identifier
// zero with a full mask, so no clearing pass over the table is needed.
// ---------------------------------------------------------------------------
module can_rx_acceptance_filter #(
    parameter int unsigned NUM_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [caf_pkg::COUNT_W-1:0]   cfg_wdata,

    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [caf_pkg::INDEX_W-1:0]   entry_index,
    input  logic [caf_pkg::IDENT_W-1:0]   entry_ident,
    input  logic [caf_pkg::IDENT_W-1:0]   entry_mask,
    input  logic                          entry_rtr,
    input  logic [caf_pkg::IDENT_W-1:0]   frame_ident,
    input  logic                          frame_rtr,
    input  logic [caf_pkg::DLC_W-1:0]     frame_dlc,
    input  logic [caf_pkg::DATA_W-1:0]    frame_data,

    output logic                          done,
    output logic                          status,
    output logic                          matched,
    output logic                          deliver,
    output logic [caf_pkg::INDEX_W-1:0]   match_index,
    output logic [caf_pkg::DLC_W-1:0]     out_dlc,
    output logic [caf_pkg::DATA_W-1:0]    out_data
);

    localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int unsigned CMP_W = (CNT_W > caf_pkg::COUNT_W) ? CNT_W : caf_pkg::COUNT_W;

    // Sequencer and control registers.
    caf_pkg::state_t                  state_reg, state_next;
    logic [caf_pkg::COUNT_W-1:0]      active_reg;
    logic [NUM_ENTRIES-1:0]           valid_reg;
    logic [IDX_W-1:0]                 ptr_reg, ptr_next;
    logic [IDX_W-1:0]                 cmp_reg, cmp_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             done_reg, done_next;

    // Payload registers.
    logic [caf_pkg::KEY_W-1:0]        key_reg, key_next;
    logic                             status_reg, status_next;
    logic                             matched_reg, matched_next;
    logic                             deliver_reg, deliver_next;
    logic [caf_pkg::INDEX_W-1:0]      index_reg, index_next;
    logic [caf_pkg::DLC_W-1:0]        dlc_reg, dlc_next;
    logic [caf_pkg::DATA_W-1:0]       data_reg, data_next;

    // Table memory and its registered read port.
    caf_pkg::entry_t                  table_mem [NUM_ENTRIES];
    caf_pkg::entry_t                  rd_entry_reg;
    logic                             rd_valid_reg;

    logic                             mem_we;
    logic [IDX_W-1:0]                 wr_addr;
    caf_pkg::entry_t                  wr_entry;
    logic [CMP_W-1:0]                 active_wide;
    logic [CNT_W-1:0]                 used_count;
    logic                             index_ok;
    logic                             last_entry;
    caf_pkg::verdict_t                verdict;

    // Number of entries in use, limited to the table size.
    always_comb
    begin
        active_wide = CMP_W'(active_reg);
        if (active_wide > CMP_W'(NUM_ENTRIES))
        begin
            used_count = CNT_W'(NUM_ENTRIES);
        end
        else
        begin
            used_count = CNT_W'(active_wide);
        end
    end

    assign index_ok   = (CMP_W'(entry_index) < CMP_W'(used_count));
    assign wr_addr    = IDX_W'(entry_index);
    assign wr_entry   = '{ident: {entry_rtr, entry_ident}, mask: entry_mask};
    assign last_entry = ((CNT_W'(cmp_reg) + CNT_W'(1)) == count_reg);

    // Shared compare unit, fed from the memory read register.
    caf_compare u_compare (
        .frame_key   (key_reg),
        .entry       (rd_entry_reg),
        .entry_valid (rd_valid_reg),
        .verdict     (verdict)
    );

    // Sequencer: configure words finish at once, frame words walk the table.
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        cmp_next     = cmp_reg;
        count_next   = count_reg;
        done_next    = 1'b0;
        key_next     = key_reg;
        status_next  = status_reg;
        matched_next = matched_reg;
        deliver_next = deliver_reg;
        index_next   = index_reg;
        dlc_next     = dlc_reg;
        data_next    = data_reg;
        mem_we       = 1'b0;

        unique case (state_reg)
            caf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    matched_next = 1'b0;
                    deliver_next = 1'b0;
                    index_next   = '0;
                    if (action == caf_pkg::ACT_CONFIG)
                    begin
                        done_next   = 1'b1;
                        mem_we      = index_ok;
                        status_next = index_ok ? caf_pkg::STATUS_OK : caf_pkg::STATUS_ILLEGAL;
                        dlc_next    = '0;
                        data_next   = '0;
                    end
                    else
                    begin
                        status_next = caf_pkg::STATUS_OK;
                        key_next    = {frame_rtr, frame_ident};
                        dlc_next    = frame_dlc;
                        data_next   = frame_data;
                        count_next  = used_count;
                        ptr_next    = '0;
                        if (used_count == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = caf_pkg::ST_LOAD;
                        end
                    end
                end
            end

            caf_pkg::ST_LOAD:
            begin
                // Entry zero is arriving in the read register.
                cmp_next   = ptr_reg;
                ptr_next   = ptr_reg + IDX_W'(1);
                state_next = caf_pkg::ST_SCAN;
            end

            caf_pkg::ST_SCAN:
            begin
                if (verdict.hit)
                begin
                    done_next    = 1'b1;
                    matched_next = 1'b1;
                    deliver_next = verdict.deliver;
                    index_next   = caf_pkg::INDEX_W'(cmp_reg);
                    state_next   = caf_pkg::ST_IDLE;
                end
                else if (last_entry)
                begin
                    done_next  = 1'b1;
                    state_next = caf_pkg::ST_IDLE;
                end
                else
                begin
                    cmp_next = ptr_reg;
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = caf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= caf_pkg::ST_IDLE;
            active_reg <= '0;
            valid_reg  <= '0;
            ptr_reg    <= '0;
            cmp_reg    <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cmp_reg   <= cmp_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        status_reg  <= status_next;
        matched_reg <= matched_next;
        deliver_reg <= deliver_next;
        index_reg   <= index_next;
        dlc_reg     <= dlc_next;
        data_reg    <= data_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= table_mem[ptr_reg];
        rd_valid_reg <= valid_reg[ptr_reg];
    end

    // Outputs.
    assign busy        = (state_reg != caf_pkg::ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign matched     = matched_reg;
    assign deliver     = deliver_reg;
    assign match_index = index_reg;
    assign out_dlc     = dlc_reg;
    assign out_data    = data_reg;

endmodule

FILE: verif/acceptance_checker.sv
// ---------------------------------------------------------------------------
// Acceptance filter checker
// Watches the word and result channels of the acceptance filter, keeps its
// own copy of the filter table and the active count, predicts the result of
// every accepted word and compares each result word field by field.
// ---------------------------------------------------------------------------
module acceptance_checker #(
    parameter int unsigned NUM_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_we,
    input  logic [caf_pkg::COUNT_W-1:0]   cfg_wdata,

    input  logic                          start,
    input  logic                          busy,
    input  logic                          action,
    input  logic [caf_pkg::INDEX_W-1:0]   entry_index,
    input  logic [caf_pkg::IDENT_W-1:0]   entry_ident,
    input  logic [caf_pkg::IDENT_W-1:0]   entry_mask,
    input  logic                          entry_rtr,
    input  logic [caf_pkg::IDENT_W-1:0]   frame_ident,
    input  logic                          frame_rtr,
    input  logic [caf_pkg::DLC_W-1:0]     frame_dlc,
    input  logic [caf_pkg::DATA_W-1:0]    frame_data,

    input  logic                          done,
    input  logic                          status,
    input  logic                          matched,
    input  logic                          deliver,
    input  logic [caf_pkg::INDEX_W-1:0]   match_index,
    input  logic [caf_pkg::DLC_W-1:0]     out_dlc,
    input  logic [caf_pkg::DATA_W-1:0]    out_data,

    output int                            mismatches,
    output int                            outstanding
);

    // One input word, in port order.
    typedef struct packed {
        logic                        action;
        logic [caf_pkg::INDEX_W-1:0] entry_index;
        logic [caf_pkg::IDENT_W-1:0] entry_ident;
        logic [caf_pkg::IDENT_W-1:0] entry_mask;
        logic                        entry_rtr;
        logic [caf_pkg::IDENT_W-1:0] frame_ident;
        logic                        frame_rtr;
        logic [caf_pkg::DLC_W-1:0]   frame_dlc;
        logic [caf_pkg::DATA_W-1:0]  frame_data;
    } filter_word_t;

    // One result word, in port order.
    typedef struct packed {
        logic                        status;
        logic                        matched;
        logic                        deliver;
        logic [caf_pkg::INDEX_W-1:0] match_index;
        logic [caf_pkg::DLC_W-1:0]   out_dlc;
        logic [caf_pkg::DATA_W-1:0]  out_data;
    } filter_result_t;

    // Shadow of the filter table; bit 11 of key and mask carries RTR.
    logic [caf_pkg::KEY_W-1:0]   entry_key  [NUM_ENTRIES];
    logic [caf_pkg::KEY_W-1:0]   entry_cmp  [NUM_ENTRIES];
    logic                        entry_owned[NUM_ENTRIES];
    logic [caf_pkg::COUNT_W-1:0] active_count;

    filter_result_t expected_results[$];
    filter_result_t want;
    filter_word_t   word_in;
    filter_result_t seen;

    assign word_in = {action, entry_index, entry_ident, entry_mask, entry_rtr,
                      frame_ident, frame_rtr, frame_dlc, frame_data};
    assign seen    = {status, matched, deliver, match_index, out_dlc, out_data};

    // Applies one word to the shadow table and returns the result it earns.
    function automatic filter_result_t filter_outcome(input filter_word_t w);
        filter_result_t            r;
        int unsigned               limit;
        logic [caf_pkg::KEY_W-1:0] key;
        r = '0;
        limit = (active_count > NUM_ENTRIES) ? NUM_ENTRIES : active_count;
        if (w.action == caf_pkg::ACT_CONFIG)
        begin
            if (w.entry_index < limit)
            begin
                entry_key[w.entry_index]   = {w.entry_rtr, w.entry_ident};
                entry_cmp[w.entry_index]   = {1'b1, w.entry_mask};
                entry_owned[w.entry_index] = 1'b1;
                r.status = caf_pkg::STATUS_OK;
            end
            else
            begin
                r.status = caf_pkg::STATUS_ILLEGAL;
            end
        end
        else
        begin
            key = {w.frame_rtr, w.frame_ident};
            // The first active entry that agrees on every masked bit wins.
            for (int i = 0; i < limit; i++)
            begin
                if (!r.matched && ((key ^ entry_key[i]) & entry_cmp[i]) == '0)
                begin
                    r.matched     = 1'b1;
                    r.deliver     = entry_owned[i];
                    r.match_index = caf_pkg::INDEX_W'(i);
                end
            end
            r.out_dlc  = w.frame_dlc;
            r.out_data = w.frame_data;
        end
        return r;
    endfunction

    task automatic report_field(input string field,
                                input logic [caf_pkg::DATA_W-1:0] exp_val,
                                input logic [caf_pkg::DATA_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
            mismatches++;
        end
    endtask

    // Register writes, predictions on accept and comparisons on done.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                entry_key[i]   = '0;
                entry_cmp[i]   = '1;
                entry_owned[i] = 1'b0;
            end
            active_count = '0;
            expected_results.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                active_count = cfg_wdata;
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected nothing, actual %0h",
                             $time, seen);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("status", want.status, seen.status);
                    report_field("matched", want.matched, seen.matched);
                    report_field("deliver", want.deliver, seen.deliver);
                    report_field("match_index", want.match_index, seen.match_index);
                    report_field("out_dlc", want.out_dlc, seen.out_dlc);
                    report_field("out_data", want.out_data, seen.out_data);
                end
            end
            if (start && !busy)
                expected_results.push_back(filter_outcome(word_in));
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// Acceptance filter testbench
// Drives configure and frame words into the acceptance filter in random
// bursts across several active-count settings, after a short directed
// sequence; the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;

    localparam int unsigned ENTRIES       = 16;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned WORDS_PER_SET = 78;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [caf_pkg::COUNT_W-1:0]  cfg_wdata;
    logic                         start;
    logic                         busy;
    logic                         action;
    logic [caf_pkg::INDEX_W-1:0]  entry_index;
    logic [caf_pkg::IDENT_W-1:0]  entry_ident;
    logic [caf_pkg::IDENT_W-1:0]  entry_mask;
    logic                         entry_rtr;
    logic [caf_pkg::IDENT_W-1:0]  frame_ident;
    logic                         frame_rtr;
    logic [caf_pkg::DLC_W-1:0]    frame_dlc;
    logic [caf_pkg::DATA_W-1:0]   frame_data;
    logic                         done;
    logic                         status;
    logic                         matched;
    logic                         deliver;
    logic [caf_pkg::INDEX_W-1:0]  match_index;
    logic [caf_pkg::DLC_W-1:0]    out_dlc;
    logic [caf_pkg::DATA_W-1:0]   out_data;

    int                           mismatches;
    int                           outstanding;
    int unsigned                  quiet_cycles = 0;

    // What has been written, kept only to aim frames at live entries.
    int unsigned                  active_setting;
    logic [caf_pkg::KEY_W-1:0]    aim_key [ENTRIES];
    logic [caf_pkg::KEY_W-1:0]    aim_mask[ENTRIES];

    can_rx_acceptance_filter #(
        .NUM_ENTRIES (ENTRIES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .entry_index (entry_index),
        .entry_ident (entry_ident),
        .entry_mask  (entry_mask),
        .entry_rtr   (entry_rtr),
        .frame_ident (frame_ident),
        .frame_rtr   (frame_rtr),
        .frame_dlc   (frame_dlc),
        .frame_data  (frame_data),
        .done        (done),
        .status      (status),
        .matched     (matched),
        .deliver     (deliver),
        .match_index (match_index),
        .out_dlc     (out_dlc),
        .out_data    (out_data)
    );

    acceptance_checker #(
        .NUM_ENTRIES (ENTRIES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .entry_index (entry_index),
        .entry_ident (entry_ident),
        .entry_mask  (entry_mask),
        .entry_rtr   (entry_rtr),
        .frame_ident (frame_ident),
        .frame_rtr   (frame_rtr),
        .frame_dlc   (frame_dlc),
        .frame_data  (frame_data),
        .done        (done),
        .status      (status),
        .matched     (matched),
        .deliver     (deliver),
        .match_index (match_index),
        .out_dlc     (out_dlc),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Count cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned used_entries();
        return (active_setting > ENTRIES) ? ENTRIES : active_setting;
    endfunction

    // Holds start high until the block takes the word.
    task automatic offer_word();
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    task automatic send_config(input logic [caf_pkg::INDEX_W-1:0] idx,
                               input logic [caf_pkg::IDENT_W-1:0] ident,
                               input logic [caf_pkg::IDENT_W-1:0] mask,
                               input logic rtr);
        action      <= caf_pkg::ACT_CONFIG;
        entry_index <= idx;
        entry_ident <= ident;
        entry_mask  <= mask;
        entry_rtr   <= rtr;
        frame_ident <= caf_pkg::IDENT_W'($urandom);
        frame_rtr   <= 1'($urandom);
        frame_dlc   <= caf_pkg::DLC_W'($urandom);
        frame_data  <= {$urandom, $urandom};
        if (idx < used_entries())
        begin
            aim_key[idx]  = {rtr, ident};
            aim_mask[idx] = {1'b1, mask};
        end
        offer_word();
    endtask

    task automatic send_frame(input logic [caf_pkg::IDENT_W-1:0] ident,
                              input logic rtr,
                              input logic [caf_pkg::DLC_W-1:0] dlc,
                              input logic [caf_pkg::DATA_W-1:0] data);
        action      <= caf_pkg::ACT_FRAME;
        entry_index <= caf_pkg::INDEX_W'($urandom);
        entry_ident <= caf_pkg::IDENT_W'($urandom);
        entry_mask  <= caf_pkg::IDENT_W'($urandom);
        entry_rtr   <= 1'($urandom);
        frame_ident <= ident;
        frame_rtr   <= rtr;
        frame_dlc   <= dlc;
        frame_data  <= data;
        offer_word();
    endtask

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops sending and waits until every pending result word has come back.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_active(input logic [caf_pkg::COUNT_W-1:0] count);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_setting = count;
    endtask

    // Mostly configure words for live entries and frames aimed at them.
    task automatic random_word();
        int unsigned                 pick;
        int unsigned                 slot;
        logic [caf_pkg::IDENT_W-1:0] mask;
        logic [caf_pkg::IDENT_W-1:0] ident;
        logic                        rtr;
        pick = $urandom_range(0, 9);
        if (used_entries() == 0 || $urandom_range(0, 9) == 0)
            slot = $urandom_range(0, 15);
        else
            slot = $urandom_range(0, used_entries() - 1);
        if (pick < 3)
        begin
            case ($urandom_range(0, 3))
                0:       mask = '1;
                1:       mask = '0;
                2:       mask = caf_pkg::IDENT_W'($urandom);
                default: mask = caf_pkg::IDENT_W'($urandom) | 11'h7C0;
            endcase
            send_config(caf_pkg::INDEX_W'(slot), caf_pkg::IDENT_W'($urandom), mask,
                        1'($urandom));
        end
        else
        begin
            if (pick < 8)
            begin
                // Vary only the bits the entry ignores, flipping RTR now and then.
                ident = aim_key[slot][caf_pkg::IDENT_W-1:0] ^
                        (caf_pkg::IDENT_W'($urandom) &
                         ~aim_mask[slot][caf_pkg::IDENT_W-1:0]);
                rtr   = aim_key[slot][caf_pkg::IDENT_W] ^ ($urandom_range(0, 7) == 0);
            end
            else if (pick == 8)
            begin
                ident = '0;
                rtr   = 1'($urandom);
            end
            else
            begin
                ident = caf_pkg::IDENT_W'($urandom);
                rtr   = 1'($urandom);
            end
            send_frame(ident, rtr, caf_pkg::DLC_W'($urandom), {$urandom, $urandom});
        end
    endtask

    // Reset, directed words, random phases and the verdict.
    initial
    begin
        logic [caf_pkg::COUNT_W-1:0] settings[12];
        int unsigned                 burst_left;
        bit                          no_gaps;
        settings = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'd17, 5'd2,
                     5'd12, 5'd16, 5'd9, 5'd24};
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        start       <= 1'b0;
        action      <= caf_pkg::ACT_CONFIG;
        entry_index <= '0;
        entry_ident <= '0;
        entry_mask  <= '0;
        entry_rtr   <= 1'b0;
        frame_ident <= '0;
        frame_rtr   <= 1'b0;
        frame_dlc   <= '0;
        frame_data  <= '0;
        active_setting = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            aim_key[i]  = '0;
            aim_mask[i] = '1;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // No entries active: every configure is refused and no frame matches.
        write_active(5'd0);
        send_config(4'd0, 11'h7FF, 11'h7FF, 1'b1);
        send_config(4'd15, 11'h000, 11'h000, 1'b0);
        send_frame(11'h000, 1'b0, 4'hF, '1);

        // Full table: hit on a never-written entry, RTR compare, last entry.
        write_active(5'd16);
        send_frame(11'h000, 1'b0, 4'h0, '0);
        send_config(4'd0, 11'h7FF, 11'h7FF, 1'b1);
        send_config(4'd15, 11'h000, 11'h000, 1'b0);
        send_frame(11'h7FF, 1'b1, 4'h8, 64'h5555_5555_5555_5555);
        send_frame(11'h7FF, 1'b0, 4'h1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_frame(11'h000, 1'b1, 4'h7, 64'h0123_4567_89AB_CDEF);
        send_frame(11'h000, 1'b0, 4'hF, '1);
        send_config(4'd1, 11'h2AA, 11'h555, 1'b0);
        send_frame(11'h000, 1'b0, 4'h2, 64'h8000_0000_0000_0001);

        // An active count beyond the table size acts as a full table.
        write_active(5'd31);
        send_config(4'd15, 11'h555, 11'h7FF, 1'b0);
        send_frame(11'h555, 1'b0, 4'h8, 64'hFEDC_BA98_7654_3210);

        // Shrinking the count hides entries without clearing them.
        write_active(5'd3);
        send_config(4'd3, 11'h123, 11'h7FF, 1'b0);
        send_config(4'd2, 11'h100, 11'h700, 1'b1);
        send_frame(11'h555, 1'b0, 4'h3, 64'h0);
        send_frame(11'h1FF, 1'b1, 4'h4, '1);
        write_active(5'd1);
        send_frame(11'h7FF, 1'b1, 4'hC, 64'h00FF_00FF_00FF_00FF);

        // Random phases, each under its own active count.
        foreach (settings[p])
        begin
            write_active(settings[p]);
            no_gaps    = (p % 4 == 3);
            burst_left = $urandom_range(1, 16);
            for (int n = 0; n < WORDS_PER_SET; n++)
            begin
                random_word();
                if ($urandom_range(0, 63) == 0)
                    drain_results();
                else if (!no_gaps)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        if ($urandom_range(0, 3) != 0)
                            hold_off($urandom_range(1, 8));
                    end
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
